// File: hdl/rpb_pkg.sv
// shared types, constants and functions for the rgb444 packed pixel blitter
package rpb_pkg;

	// framebuffer geometry
	localparam int FRAME_WIDTH  = 320;
	localparam int FRAME_HEIGHT = 240;

	// widths
	localparam int COLOR_W = 32;
	localparam int ADDR_W  = 17;
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;
	localparam int FCOL_W  = 10;
	localparam int FROW_W  = 9;
	localparam int CMP_W   = 11;
	localparam int PIX_W   = $clog2(FRAME_WIDTH * FRAME_HEIGHT);
	localparam int NIB_W   = PIX_W + 2;

	localparam logic [CMP_W-1:0] FRAME_WIDTH_C  = CMP_W'(FRAME_WIDTH);
	localparam logic [CMP_W-1:0] FRAME_HEIGHT_C = CMP_W'(FRAME_HEIGHT);
	localparam logic [PIX_W-1:0] FRAME_WIDTH_P  = PIX_W'(FRAME_WIDTH);

	// register indexes
	localparam logic [2:0] REG_DEST_X      = 3'd0;
	localparam logic [2:0] REG_DEST_Y      = 3'd1;
	localparam logic [2:0] REG_BMP_WIDTH   = 3'd2;
	localparam logic [2:0] REG_BMP_HEIGHT  = 3'd3;
	localparam logic [2:0] REG_RED_BITS    = 3'd4;
	localparam logic [2:0] REG_GREEN_BITS  = 3'd5;
	localparam logic [2:0] REG_BLUE_BITS   = 3'd6;
	localparam logic [2:0] REG_ALPHA_EN    = 3'd7;

	// nibble mask codes
	localparam logic [1:0] MASK_NONE = 2'b00;
	localparam logic [1:0] MASK_LOW  = 2'b01;
	localparam logic [1:0] MASK_HIGH = 2'b10;
	localparam logic [1:0] MASK_BOTH = 2'b11;

	typedef struct packed {
		logic [8:0] dest_x;
		logic [7:0] dest_y;
		logic [8:0] bmp_width;
		logic [7:0] bmp_height;
		logic [3:0] red_field_bits;
		logic [3:0] green_field_bits;
		logic [3:0] blue_field_bits;
		logic       alpha_enable;
	} cfg_t;

	typedef struct packed {
		logic             visible;
		logic [PIX_W-1:0] pix;
		logic             done;
	} pos_t;

	typedef struct packed {
		logic              write_enable;
		logic [ADDR_W-1:0] byte_address;
		logic [7:0]        first_byte;
		logic [1:0]        first_nibble_mask;
		logic [7:0]        second_byte;
		logic [1:0]        second_nibble_mask;
		logic              image_done;
	} res_t;

	// field widths above eight count as eight
	function automatic logic [3:0] clamp_bits(input logic [3:0] n);
		return (n > 4'd8) ? 4'd8 : n;
	endfunction

	// cut a field out of the source word and scale it to four bits
	function automatic logic [3:0] scale4(input logic [COLOR_W-1:0] word,
			input logic [4:0] shift, input logic [3:0] n);
		logic [7:0] win;
		logic [7:0] msk;
		logic [7:0] v;
		logic [7:0] sc;
		win = 8'(word >> shift);
		msk = 8'((9'd1 << n) - 9'd1);
		v = win & msk;
		if (n <= 4'd4) begin
			sc = v << (4'd4 - n);
		end else begin
			sc = v >> (n - 4'd4);
		end
		return sc[3:0];
	endfunction

endpackage

// File: hdl/rpb_cfg.sv
// configuration registers behind the apb-style port
module rpb_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rpb_pkg::PADDR_W-1:0]   paddr,
	input  logic [rpb_pkg::PDATA_W-1:0]   pwdata,
	output logic [rpb_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	output rpb_pkg::cfg_t                 cfg
);

	logic       wr;
	logic [2:0] idx;
	rpb_pkg::cfg_t cfg_q;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;
	assign idx    = paddr[4:2];
	assign cfg    = cfg_q;

	// register writes on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dest_x           <= 9'd0;
			cfg_q.dest_y           <= 8'd0;
			cfg_q.bmp_width        <= 9'd1;
			cfg_q.bmp_height       <= 8'd1;
			cfg_q.red_field_bits   <= 4'd4;
			cfg_q.green_field_bits <= 4'd4;
			cfg_q.blue_field_bits  <= 4'd4;
			cfg_q.alpha_enable     <= 1'b0;
		end else if (wr) begin
			unique case (idx)
				rpb_pkg::REG_DEST_X:     cfg_q.dest_x           <= pwdata[8:0];
				rpb_pkg::REG_DEST_Y:     cfg_q.dest_y           <= pwdata[7:0];
				rpb_pkg::REG_BMP_WIDTH:  cfg_q.bmp_width        <= pwdata[8:0];
				rpb_pkg::REG_BMP_HEIGHT: cfg_q.bmp_height       <= pwdata[7:0];
				rpb_pkg::REG_RED_BITS:   cfg_q.red_field_bits   <= pwdata[3:0];
				rpb_pkg::REG_GREEN_BITS: cfg_q.green_field_bits <= pwdata[3:0];
				rpb_pkg::REG_BLUE_BITS:  cfg_q.blue_field_bits  <= pwdata[3:0];
				rpb_pkg::REG_ALPHA_EN:   cfg_q.alpha_enable     <= pwdata[0];
				default:                 cfg_q.alpha_enable     <= cfg_q.alpha_enable;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (idx)
			rpb_pkg::REG_DEST_X:     prdata = 32'(cfg_q.dest_x);
			rpb_pkg::REG_DEST_Y:     prdata = 32'(cfg_q.dest_y);
			rpb_pkg::REG_BMP_WIDTH:  prdata = 32'(cfg_q.bmp_width);
			rpb_pkg::REG_BMP_HEIGHT: prdata = 32'(cfg_q.bmp_height);
			rpb_pkg::REG_RED_BITS:   prdata = 32'(cfg_q.red_field_bits);
			rpb_pkg::REG_GREEN_BITS: prdata = 32'(cfg_q.green_field_bits);
			rpb_pkg::REG_BLUE_BITS:  prdata = 32'(cfg_q.blue_field_bits);
			rpb_pkg::REG_ALPHA_EN:   prdata = 32'(cfg_q.alpha_enable);
			default:                 prdata = '0;
		endcase
	end

endmodule

// File: hdl/rpb_pos.sv
// column and row counters and framebuffer pixel index of the next pixel
module rpb_pos (
	input  logic          clk,
	input  logic          arst_n,
	input  rpb_pkg::cfg_t cfg,
	input  logic          advance,
	output rpb_pkg::pos_t pos
);

	logic [8:0] col_q;
	logic [7:0] row_q;
	logic [8:0] wlast;
	logic [7:0] hlast;
	logic       col_wrap;
	logic       row_wrap;
	logic [rpb_pkg::FCOL_W-1:0] fcol;
	logic [rpb_pkg::FROW_W-1:0] frow;

	// last indexes, zero size counts as one
	assign wlast = (cfg.bmp_width == 9'd0) ? 9'd0 : cfg.bmp_width - 9'd1;
	assign hlast = (cfg.bmp_height == 8'd0) ? 8'd0 : cfg.bmp_height - 8'd1;
	assign col_wrap = (col_q >= wlast);
	assign row_wrap = (row_q >= hlast);

	// framebuffer position and clipping
	assign fcol = rpb_pkg::FCOL_W'(cfg.dest_x) + rpb_pkg::FCOL_W'(col_q);
	assign frow = rpb_pkg::FROW_W'(cfg.dest_y) + rpb_pkg::FROW_W'(row_q);
	assign pos.visible = (rpb_pkg::CMP_W'(fcol) < rpb_pkg::FRAME_WIDTH_C) &&
		(rpb_pkg::CMP_W'(frow) < rpb_pkg::FRAME_HEIGHT_C);
	assign pos.pix = rpb_pkg::PIX_W'(frow) * rpb_pkg::FRAME_WIDTH_P +
		rpb_pkg::PIX_W'(fcol);
	assign pos.done = col_wrap && row_wrap;

	// raster counters step on each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= 9'd0;
			row_q <= 8'd0;
		end else if (advance) begin
			if (col_wrap) begin
				col_q <= 9'd0;
				row_q <= row_wrap ? 8'd0 : row_q + 8'd1;
			end else begin
				col_q <= col_q + 9'd1;
			end
		end
	end

endmodule

// File: hdl/rpb_pack.sv
// color scaling, alpha test and nibble packing of one pixel
module rpb_pack (
	input  rpb_pkg::cfg_t                 cfg,
	input  logic [rpb_pkg::COLOR_W-1:0]   color,
	input  rpb_pkg::pos_t                 pos,
	output rpb_pkg::res_t                 res
);

	logic [3:0] rb;
	logic [3:0] gb;
	logic [3:0] bb;
	logic [4:0] g_shift;
	logic [4:0] b_shift;
	logic [4:0] a_shift;
	logic [3:0] red;
	logic [3:0] green;
	logic [3:0] blue;
	logic       opaque;
	logic       we;
	logic [rpb_pkg::NIB_W-1:0] pix_ext;
	logic [rpb_pkg::NIB_W-1:0] nib;

	// field extraction
	assign rb      = rpb_pkg::clamp_bits(cfg.red_field_bits);
	assign gb      = rpb_pkg::clamp_bits(cfg.green_field_bits);
	assign bb      = rpb_pkg::clamp_bits(cfg.blue_field_bits);
	assign g_shift = 5'(rb);
	assign b_shift = 5'(rb) + 5'(gb);
	assign a_shift = b_shift + 5'(bb);
	assign red     = rpb_pkg::scale4(color, 5'd0, rb);
	assign green   = rpb_pkg::scale4(color, g_shift, gb);
	assign blue    = rpb_pkg::scale4(color, b_shift, bb);
	assign opaque  = !cfg.alpha_enable || ((color >> a_shift) != '0);
	assign we      = pos.visible && opaque;

	// nibble address is three times the pixel index
	assign pix_ext = rpb_pkg::NIB_W'(pos.pix);
	assign nib     = pix_ext + (pix_ext << 1);

	// even pixels start on a byte, odd ones mid-byte
	always_comb begin
		res = '0;
		res.image_done = pos.done;
		if (we) begin
			res.write_enable = 1'b1;
			res.byte_address = rpb_pkg::ADDR_W'(nib >> 1);
			if (!pos.pix[0]) begin
				res.first_byte         = {red, green};
				res.first_nibble_mask  = rpb_pkg::MASK_BOTH;
				res.second_byte        = {blue, 4'd0};
				res.second_nibble_mask = rpb_pkg::MASK_HIGH;
			end else begin
				res.first_byte         = {4'd0, red};
				res.first_nibble_mask  = rpb_pkg::MASK_LOW;
				res.second_byte        = {green, blue};
				res.second_nibble_mask = rpb_pkg::MASK_BOTH;
			end
		end else begin
			res.first_nibble_mask  = rpb_pkg::MASK_NONE;
			res.second_nibble_mask = rpb_pkg::MASK_NONE;
		end
	end

endmodule

// File: hdl/rgb444_packed_pixel_blitter.sv
// top level of the rgb444 packed pixel blitter
//
// Source pixels enter on the pixel channel (pixel_valid, pixel_ready,
// pixel_color) in raster order of the bitmap; each accepted pixel yields
// exactly one result on the result channel (result_valid, result_ready and
// the write fields): a nibble-masked two-byte write into a 12-bit-per-pixel
// framebuffer, or a result with write_enable low for off-screen or
// transparent pixels. image_done marks the last pixel of the bitmap.
// The pixel is registered with its framebuffer index in the first stage and
// the packed write is registered in the output stage; one pixel per cycle is
// sustained while result_ready stays high. When the receiver holds
// result_ready low, the output stage holds its result and the first stage
// takes one more pixel only if it is empty; pixel_ready then drops until the
// output stage frees. Registers must be written through the apb-style port
// only while the block is idle; the block itself does not enforce this.
// Reset clears the pipeline, the counters and loads the register defaults.
module rgb444_packed_pixel_blitter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [rpb_pkg::PADDR_W-1:0]         paddr,
	input  logic [rpb_pkg::PDATA_W-1:0]         pwdata,
	output logic [rpb_pkg::PDATA_W-1:0]         prdata,
	output logic                                pready,
	input  logic                                pixel_valid,
	output logic                                pixel_ready,
	input  logic [rpb_pkg::COLOR_W-1:0]         pixel_color,
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic                                write_enable,
	output logic [rpb_pkg::ADDR_W-1:0]          byte_address,
	output logic [7:0]                          first_byte,
	output logic [1:0]                          first_nibble_mask,
	output logic [7:0]                          second_byte,
	output logic [1:0]                          second_nibble_mask,
	output logic                                image_done
);

	rpb_pkg::cfg_t cfg;
	rpb_pkg::pos_t pos;
	rpb_pkg::pos_t pos_s1;
	rpb_pkg::res_t res;
	rpb_pkg::res_t res_s2;
	logic [rpb_pkg::COLOR_W-1:0] color_s1;
	logic valid_s1;
	logic valid_s2;
	logic adv_s2;
	logic adv_s1;

	rpb_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// handshake: each stage moves when the one after it can take data
	assign adv_s2      = !valid_s2 || result_ready;
	assign pixel_ready = !valid_s1 || adv_s2;
	assign adv_s1      = pixel_valid && pixel_ready;

	rpb_pos u_pos (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.advance (adv_s1),
		.pos     (pos)
	);

	// first stage: pixel and its framebuffer index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixel_ready) begin
			valid_s1 <= pixel_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			color_s1 <= pixel_color;
			pos_s1   <= pos;
		end
	end

	rpb_pack u_pack (
		.cfg   (cfg),
		.color (color_s1),
		.pos   (pos_s1),
		.res   (res)
	);

	// output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			res_s2 <= res;
		end
	end

	assign result_valid       = valid_s2;
	assign write_enable       = res_s2.write_enable;
	assign byte_address       = res_s2.byte_address;
	assign first_byte         = res_s2.first_byte;
	assign first_nibble_mask  = res_s2.first_nibble_mask;
	assign second_byte        = res_s2.second_byte;
	assign second_nibble_mask = res_s2.second_nibble_mask;
	assign image_done         = res_s2.image_done;

endmodule
